// File: hdl/xea_pkg.sv
// xea_pkg: shared types and codes for the x86 effective address unit
// item and result payload structs, ModRM field codes, register numbers
// no dependencies
`default_nettype none

package xea_pkg;

    // action codes
    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_RESOLVE = 1'b1;

    // addressing size select
    localparam logic ASIZE_16 = 1'b0;
    localparam logic ASIZE_32 = 1'b1;

    // ModRM mod field
    localparam logic [1:0] MOD_NO_DISP = 2'd0;
    localparam logic [1:0] MOD_DISP8   = 2'd1;
    localparam logic [1:0] MOD_DISP32  = 2'd2;
    localparam logic [1:0] MOD_REG     = 2'd3;

    // general register numbers
    localparam logic [2:0] REG_EAX = 3'd0;
    localparam logic [2:0] REG_ECX = 3'd1;
    localparam logic [2:0] REG_EDX = 3'd2;
    localparam logic [2:0] REG_EBX = 3'd3;
    localparam logic [2:0] REG_ESP = 3'd4;
    localparam logic [2:0] REG_EBP = 3'd5;
    localparam logic [2:0] REG_ESI = 3'd6;
    localparam logic [2:0] REG_EDI = 3'd7;

    // rm values with fixed meaning
    localparam logic [2:0] RM_SIB     = 3'd4;
    localparam logic [2:0] RM_DISP32  = 3'd5;
    localparam logic [2:0] RM16_DISP  = 3'd6;
    localparam logic [2:0] SIB_NO_IDX = 3'd4;

    // result status codes
    localparam logic STAT_OK       = 1'b0;
    localparam logic STAT_REG_FORM = 1'b1;

    localparam int NUM_REGS = 8;
    localparam int REG_W    = 32;

    typedef struct packed {
        logic        action;
        logic [2:0]  reg_index;
        logic [31:0] reg_value;
        logic [7:0]  modrm;
        logic [7:0]  sib;
        logic [31:0] displacement;
        logic [31:0] data_seg_base;
        logic [31:0] stack_seg_base;
        logic        addr32;
    } xea_in_t;

    typedef struct packed {
        logic [31:0] linear_address;
        logic        used_stack_segment;
        logic [2:0]  extra_bytes;
        logic        status;
    } xea_out_t;

endpackage

`default_nettype wire

// File: hdl/xea_regfile.sv
// xea_regfile: eight-entry general register file, one write and two read ports
// read data is registered; valid bits make unwritten entries read as zero
// depends on xea_pkg
`default_nettype none

module xea_regfile (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 wr_en,
    input  wire logic [$clog2(xea_pkg::NUM_REGS)-1:0] wr_addr,
    input  wire logic [xea_pkg::REG_W-1:0]            wr_data,
    input  wire logic                                 rd_en,
    input  wire logic [$clog2(xea_pkg::NUM_REGS)-1:0] rd_addr_a,
    input  wire logic [$clog2(xea_pkg::NUM_REGS)-1:0] rd_addr_b,
    output logic      [xea_pkg::REG_W-1:0]            rd_data_a,
    output logic      [xea_pkg::REG_W-1:0]            rd_data_b
);

    logic [xea_pkg::REG_W-1:0]    mem_reg [xea_pkg::NUM_REGS];
    logic [xea_pkg::NUM_REGS-1:0] written_reg;
    logic [xea_pkg::REG_W-1:0]    rd_a_reg;
    logic [xea_pkg::REG_W-1:0]    rd_b_reg;

    // storage write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // per-entry written flags, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr_en)
        begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

    // registered reads, zero for entries not yet written
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= written_reg[rd_addr_a] ? mem_reg[rd_addr_a] : '0;
            rd_b_reg <= written_reg[rd_addr_b] ? mem_reg[rd_addr_b] : '0;
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

// File: hdl/xea_calc.sv
// xea_calc: combinational address formation for one registered item
// 16-bit and 32-bit ModRM/SIB forms, segment select and byte count
// depends on xea_pkg
`default_nettype none

module xea_calc (
    input  wire xea_pkg::xea_in_t  item,
    input  wire logic [31:0]       base_val,
    input  wire logic [31:0]       index_val,
    output xea_pkg::xea_out_t      result
);

    logic [1:0]  mod_f;
    logic [2:0]  rm_f;
    logic [1:0]  scale_f;
    logic [2:0]  index_f;
    logic [2:0]  base_f;
    logic [31:0] disp8_sx;
    logic [15:0] base16;
    logic [15:0] disp16;
    logic [15:0] off16;
    logic [31:0] base32;
    logic [31:0] index32;
    logic [31:0] disp32;
    logic [31:0] off32;
    logic [31:0] offset;
    logic        stk;
    logic [2:0]  extra;

    assign mod_f    = item.modrm[7:6];
    assign rm_f     = item.modrm[2:0];
    assign scale_f  = item.sib[7:6];
    assign index_f  = item.sib[5:3];
    assign base_f   = item.sib[2:0];
    assign disp8_sx = {{24{item.displacement[7]}}, item.displacement[7:0]};

    // address form decode and offset sum
    always_comb
    begin
        base16  = '0;
        disp16  = '0;
        off16   = '0;
        base32  = '0;
        index32 = '0;
        disp32  = '0;
        off32   = '0;
        stk     = 1'b0;
        extra   = '0;
        if (item.addr32 == xea_pkg::ASIZE_16)
        begin
            // base pair: register a plus si/di for the two-register forms
            if (rm_f[2] == 1'b0)
            begin
                base16 = base_val[15:0] + index_val[15:0];
            end
            else
            begin
                base16 = base_val[15:0];
            end
            // forms built on bp
            stk = rm_f inside {3'd2, 3'd3, xea_pkg::RM16_DISP};
            case (mod_f)
                xea_pkg::MOD_NO_DISP:
                begin
                    if (rm_f == xea_pkg::RM16_DISP)
                    begin
                        base16 = '0;
                        stk    = 1'b0;
                        disp16 = item.displacement[15:0];
                        extra  = 3'd2;
                    end
                end
                xea_pkg::MOD_DISP8:
                begin
                    disp16 = disp8_sx[15:0];
                    extra  = 3'd1;
                end
                default:
                begin
                    disp16 = item.displacement[15:0];
                    extra  = 3'd2;
                end
            endcase
            off16  = base16 + disp16;
            offset = {16'd0, off16};
        end
        else
        begin
            if (rm_f == xea_pkg::RM_SIB)
            begin
                extra = 3'd1;
                if (base_f == xea_pkg::REG_EBP && mod_f == xea_pkg::MOD_NO_DISP)
                begin
                    base32 = item.displacement;
                    extra  = 3'd5;
                end
                else
                begin
                    base32 = base_val;
                    stk    = base_f inside {xea_pkg::REG_ESP, xea_pkg::REG_EBP};
                end
                if (index_f != xea_pkg::SIB_NO_IDX)
                begin
                    index32 = index_val << scale_f;
                end
            end
            else if (rm_f == xea_pkg::RM_DISP32 && mod_f == xea_pkg::MOD_NO_DISP)
            begin
                base32 = item.displacement;
                extra  = 3'd4;
            end
            else
            begin
                base32 = base_val;
                stk    = (rm_f == xea_pkg::REG_EBP);
            end
            // trailing displacement
            case (mod_f)
                xea_pkg::MOD_DISP8:
                begin
                    disp32 = disp8_sx;
                    extra  = extra + 3'd1;
                end
                xea_pkg::MOD_DISP32:
                begin
                    disp32 = item.displacement;
                    extra  = extra + 3'd4;
                end
                default:
                begin
                    disp32 = '0;
                end
            endcase
            off32  = base32 + index32 + disp32;
            offset = off32;
        end
    end

    // segment add and special cases
    always_comb
    begin
        result = '0;
        if (item.action == xea_pkg::ACT_RESOLVE)
        begin
            if (mod_f == xea_pkg::MOD_REG)
            begin
                result.status = xea_pkg::STAT_REG_FORM;
            end
            else
            begin
                result.linear_address     = (stk ? item.stack_seg_base
                                                 : item.data_seg_base) + offset;
                result.used_stack_segment = stk;
                result.extra_bytes        = extra;
                result.status             = xea_pkg::STAT_OK;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/x86_effective_address.sv
// x86 effective address unit, top level
//
// Usage:
//   item channel (item_valid / item_stall / item) carries either a register
//   write (action 0: reg_index, reg_value) or an address request (action 1:
//   modrm, sib, displacement, segment bases, addr32). Every item gives exactly
//   one result on the result channel (result_valid / result_stall / result).
//   A write item returns an all-zero result; a register-form ModRM (mod 3)
//   returns status 1 with the other fields zero.
//   An accepted item passes through the register file read port into the
//   operand register, then through the address adders into the result
//   register. Throughput is one item per cycle while item_stall is low; a
//   write is visible to the very next item. The two register-file read ports
//   supply base and index.
//   When result_stall is high the result register holds and the operand
//   stage keeps working until it is full, then item_stall rises.
//   Reset (rst_n low, asynchronous) empties both stages and makes all eight
//   general registers read as zero.
// depends on xea_pkg, xea_regfile, xea_calc
`default_nettype none

module x86_effective_address (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire xea_pkg::xea_in_t  item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output xea_pkg::xea_out_t      result
);

    logic              accept;
    logic              advance;
    logic              op_valid_reg;
    logic              op_valid_next;
    xea_pkg::xea_in_t  op_item_reg;
    logic              res_valid_reg;
    logic              res_valid_next;
    xea_pkg::xea_out_t res_reg;
    xea_pkg::xea_out_t calc_out;
    logic [2:0]        addr_a;
    logic [2:0]        addr_b;
    logic [31:0]       rd_a;
    logic [31:0]       rd_b;
    logic              wr_en;

    // handshake
    assign advance    = op_valid_reg && (!res_valid_reg || !result_stall);
    assign item_stall = op_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;
    assign wr_en      = accept && (item.action == xea_pkg::ACT_WRITE);

    // read port selection: port a is base, port b is si/di or sib index
    always_comb
    begin
        addr_a = item.modrm[2:0];
        addr_b = item.sib[5:3];
        if (item.addr32 == xea_pkg::ASIZE_16)
        begin
            case (item.modrm[2:0])
                3'd0:
                begin
                    addr_a = xea_pkg::REG_EBX;
                    addr_b = xea_pkg::REG_ESI;
                end
                3'd1:
                begin
                    addr_a = xea_pkg::REG_EBX;
                    addr_b = xea_pkg::REG_EDI;
                end
                3'd2:
                begin
                    addr_a = xea_pkg::REG_EBP;
                    addr_b = xea_pkg::REG_ESI;
                end
                3'd3:
                begin
                    addr_a = xea_pkg::REG_EBP;
                    addr_b = xea_pkg::REG_EDI;
                end
                3'd4:    addr_a = xea_pkg::REG_ESI;
                3'd5:    addr_a = xea_pkg::REG_EDI;
                3'd6:    addr_a = xea_pkg::REG_EBP;
                default: addr_a = xea_pkg::REG_EBX;
            endcase
        end
        else if (item.modrm[2:0] == xea_pkg::RM_SIB)
        begin
            addr_a = item.sib[2:0];
        end
    end

    xea_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (item.reg_index),
        .wr_data   (item.reg_value),
        .rd_en     (accept),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    xea_calc u_calc (
        .item      (op_item_reg),
        .base_val  (rd_a),
        .index_val (rd_b),
        .result    (calc_out)
    );

    // stage valid next values
    assign op_valid_next  = accept || (op_valid_reg && !advance);
    assign res_valid_next = advance || (res_valid_reg && result_stall);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg  <= op_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_item_reg <= item;
        end
        if (advance)
        begin
            res_reg <= calc_out;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

// File: verif/tb_x86_effective_address.sv
// tb_x86_effective_address: self-checking testbench for the x86 effective address unit
// directed table then random items, checked against an in-bench address predictor
// depends on xea_pkg and x86_effective_address
module tb_x86_effective_address;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int NUM_DIRECTED = 25;
    localparam int REPORT_MAX   = 10;
    localparam int DRAIN_CYCLES = 4;

    typedef struct {
        xea_pkg::xea_in_t  stim;
        logic              known;
        xea_pkg::xea_out_t want;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    xea_pkg::xea_in_t  item;
    logic              result_valid;
    logic              result_stall = 1'b0;
    xea_pkg::xea_out_t result;

    // typed expectation that travels with the item being offered
    logic              item_known;
    xea_pkg::xea_out_t item_want;

    logic [xea_pkg::REG_W-1:0] arch_regs [xea_pkg::NUM_REGS];
    xea_pkg::xea_out_t         pending_results [$];
    dir_row_t                  dir_rows [NUM_DIRECTED];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count = 0;
    int cycle_count = 0;

    x86_effective_address dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // low 16 bits of a general register
    function automatic logic [15:0] reg16(input logic [2:0] idx);
        return arch_regs[idx][15:0];
    endfunction

    // predicted result of one item; a write item updates the register file
    function automatic xea_pkg::xea_out_t resolve_operand(input xea_pkg::xea_in_t it);
        xea_pkg::xea_out_t r;
        logic [1:0]  md;
        logic [2:0]  rm;
        logic [15:0] sum16;
        logic [15:0] disp16;
        logic [31:0] off;
        logic [31:0] disp8x;
        logic [2:0]  sb;
        logic [2:0]  si;
        logic [1:0]  sc;
        logic        stk;
        r      = '0;
        md     = it.modrm[7:6];
        rm     = it.modrm[2:0];
        stk    = 1'b0;
        disp8x = {{24{it.displacement[7]}}, it.displacement[7:0]};
        if (it.action == xea_pkg::ACT_WRITE)
        begin
            arch_regs[it.reg_index] = it.reg_value;
        end
        else if (md == xea_pkg::MOD_REG)
        begin
            r.status = xea_pkg::STAT_REG_FORM;
        end
        else if (it.addr32 == xea_pkg::ASIZE_16)
        begin
            // 16-bit base: BX/BP plus SI/DI, or a single register
            if (!rm[2])
            begin
                sum16 = (rm[1] ? reg16(xea_pkg::REG_EBP) : reg16(xea_pkg::REG_EBX))
                      + (rm[0] ? reg16(xea_pkg::REG_EDI) : reg16(xea_pkg::REG_ESI));
                stk   = rm[1];
            end
            else
            begin
                case (rm[1:0])
                    2'b00:   sum16 = reg16(xea_pkg::REG_ESI);
                    2'b01:   sum16 = reg16(xea_pkg::REG_EDI);
                    2'b10:   sum16 = reg16(xea_pkg::REG_EBP);
                    default: sum16 = reg16(xea_pkg::REG_EBX);
                endcase
                stk = (rm == xea_pkg::RM16_DISP);
            end
            disp16 = '0;
            if (md == xea_pkg::MOD_NO_DISP)
            begin
                // bare disp16 in the data segment
                if (rm == xea_pkg::RM16_DISP)
                begin
                    sum16         = '0;
                    stk           = 1'b0;
                    disp16        = it.displacement[15:0];
                    r.extra_bytes = 3'd2;
                end
            end
            else if (md == xea_pkg::MOD_DISP8)
            begin
                disp16        = disp8x[15:0];
                r.extra_bytes = 3'd1;
            end
            else
            begin
                disp16        = it.displacement[15:0];
                r.extra_bytes = 3'd2;
            end
            sum16 = sum16 + disp16;
            r.linear_address = (stk ? it.stack_seg_base : it.data_seg_base)
                             + {16'h0, sum16};
        end
        else
        begin
            // 32-bit forms
            if (rm == xea_pkg::RM_SIB)
            begin
                sb = it.sib[2:0];
                si = it.sib[5:3];
                sc = it.sib[7:6];
                r.extra_bytes = 3'd1;
                if (sb == xea_pkg::REG_ESP)
                begin
                    off = arch_regs[xea_pkg::REG_ESP];
                    stk = 1'b1;
                end
                else if (sb == xea_pkg::REG_EBP)
                begin
                    if (md == xea_pkg::MOD_NO_DISP)
                    begin
                        off           = it.displacement;
                        r.extra_bytes = r.extra_bytes + 3'd4;
                    end
                    else
                    begin
                        off = arch_regs[xea_pkg::REG_EBP];
                        stk = 1'b1;
                    end
                end
                else
                begin
                    off = arch_regs[sb];
                end
                if (si != xea_pkg::SIB_NO_IDX)
                    off = off + (arch_regs[si] << sc);
            end
            else if (rm == xea_pkg::RM_DISP32 && md == xea_pkg::MOD_NO_DISP)
            begin
                off           = it.displacement;
                r.extra_bytes = 3'd4;
            end
            else
            begin
                off = arch_regs[rm];
                stk = (rm == xea_pkg::REG_EBP);
            end
            if (md == xea_pkg::MOD_DISP8)
            begin
                off           = off + disp8x;
                r.extra_bytes = r.extra_bytes + 3'd1;
            end
            else if (md == xea_pkg::MOD_DISP32)
            begin
                off           = off + it.displacement;
                r.extra_bytes = r.extra_bytes + 3'd4;
            end
            r.linear_address = (stk ? it.stack_seg_base : it.data_seg_base) + off;
        end
        r.used_stack_segment = stk;
        return r;
    endfunction

    // 32-bit value biased toward edges
    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h0000_FFFF;
            4:       return 32'h0000_0080;
            5:       return 32'hFFFF_FF7F;
            default: return $urandom;
        endcase
    endfunction

    function automatic xea_pkg::xea_in_t rand_item();
        xea_pkg::xea_in_t it;
        it.action         = ($urandom_range(99) < 25) ? xea_pkg::ACT_WRITE
                                                      : xea_pkg::ACT_RESOLVE;
        it.reg_index      = 3'($urandom_range(xea_pkg::NUM_REGS - 1));
        it.reg_value      = rand_word();
        it.modrm          = 8'($urandom_range(255));
        it.sib            = 8'($urandom_range(255));
        it.displacement   = rand_word();
        it.data_seg_base  = rand_word();
        it.stack_seg_base = rand_word();
        it.addr32         = $urandom_range(1) ? xea_pkg::ASIZE_32 : xea_pkg::ASIZE_16;
        return it;
    endfunction

    // register write with every unused field at all ones
    function automatic xea_pkg::xea_in_t mk_write(input logic [2:0] idx,
                                                  input logic [31:0] val);
        xea_pkg::xea_in_t it;
        it           = '1;
        it.action    = xea_pkg::ACT_WRITE;
        it.reg_index = idx;
        it.reg_value = val;
        return it;
    endfunction

    function automatic xea_pkg::xea_in_t mk_addr(input logic a32, input logic [7:0] modrm,
                                                 input logic [7:0] sib,
                                                 input logic [31:0] disp,
                                                 input logic [31:0] dseg,
                                                 input logic [31:0] sseg);
        xea_pkg::xea_in_t it;
        it.action         = xea_pkg::ACT_RESOLVE;
        it.reg_index      = xea_pkg::REG_EAX;
        it.reg_value      = '0;
        it.modrm          = modrm;
        it.sib            = sib;
        it.displacement   = disp;
        it.data_seg_base  = dseg;
        it.stack_seg_base = sseg;
        it.addr32         = a32;
        return it;
    endfunction

    // offer one item, holding it until it is taken
    task automatic send_item(input xea_pkg::xea_in_t it, input logic known,
                             input xea_pkg::xea_out_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= it;
        item_known <= known;
        item_want  <= want;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall) @(posedge clk);
    endtask

    // receiver stall
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // prediction on accepted items, checking of accepted results
    always @(posedge clk)
    begin : scoreboard
        xea_pkg::xea_out_t want;
        xea_pkg::xea_out_t pred;
        if (!rst_n)
        begin
            for (int k = 0; k < xea_pkg::NUM_REGS; k++)
                arch_regs[k] = '0;
        end
        if (result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("result with none expected: addr %h stk %b extra %0d status %b",
                             result.linear_address, result.used_stack_segment,
                             result.extra_bytes, result.status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.linear_address !== want.linear_address
                    || result.used_stack_segment !== want.used_stack_segment
                    || result.extra_bytes !== want.extra_bytes
                    || result.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display({"mismatch: exp addr %h stk %b extra %0d status %b, ",
                                  "got addr %h stk %b extra %0d status %b"},
                                 want.linear_address, want.used_stack_segment,
                                 want.extra_bytes, want.status,
                                 result.linear_address, result.used_stack_segment,
                                 result.extra_bytes, result.status);
                end
            end
        end
        if (rst_n && item_valid && !item_stall)
        begin
            pred = resolve_operand(item);
            pending_results.push_back(item_known ? item_want : pred);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        xea_pkg::xea_out_t none;
        none           = '0;
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        item_known     = 1'b0;
        item_want      = '0;
        send_idle_pct  = 13;
        recv_idle_pct  = 47;

        // directed table
        dir_rows[0] = '{mk_addr(xea_pkg::ASIZE_32,
                                {xea_pkg::MOD_NO_DISP, 3'd0, xea_pkg::REG_EAX}, 8'h00, '0,
                                32'h0000_1000, 32'h0000_2000), 1'b1,
                        '{linear_address: 32'h0000_1000, used_stack_segment: 1'b0,
                          extra_bytes: 3'd0, status: xea_pkg::STAT_OK}};
        dir_rows[1] = '{mk_addr(xea_pkg::ASIZE_32,
                                {xea_pkg::MOD_REG, 3'd7, xea_pkg::REG_EDI}, 8'hFF,
                                '1, '1, '1), 1'b1,
                        '{linear_address: '0, used_stack_segment: 1'b0,
                          extra_bytes: 3'd0, status: xea_pkg::STAT_REG_FORM}};
        dir_rows[2] = '{mk_write(xea_pkg::REG_EAX, 32'hFFFF_FFFF), 1'b1, none};
        dir_rows[3] = '{mk_write(xea_pkg::REG_ECX, 32'h8000_0000), 1'b1, none};
        dir_rows[4] = '{mk_write(xea_pkg::REG_EDX, 32'h7FFF_FFFF), 1'b1, none};
        dir_rows[5] = '{mk_write(xea_pkg::REG_EBX, 32'h0000_FFFF), 1'b1, none};
        dir_rows[6] = '{mk_write(xea_pkg::REG_ESP, 32'hFFFF_0010), 1'b1, none};
        dir_rows[7] = '{mk_write(xea_pkg::REG_EBP, 32'h1234_8000), 1'b1, none};
        dir_rows[8] = '{mk_write(xea_pkg::REG_ESI, 32'h0000_8001), 1'b1, none};
        dir_rows[9] = '{mk_write(xea_pkg::REG_EDI, 32'hABCD_FFFE), 1'b1, none};
        // 16-bit forms without displacement, bare disp16 among them
        for (int k = 0; k < 8; k++)
            dir_rows[10 + k] = '{mk_addr(xea_pkg::ASIZE_16,
                                         {xea_pkg::MOD_NO_DISP, 3'd0, 3'(k)}, 8'h00,
                                         32'h5555_ABCD, 32'h0001_0000, 32'hFFFF_F000),
                                 1'b0, none};
        dir_rows[18] = '{mk_addr(xea_pkg::ASIZE_16, {xea_pkg::MOD_DISP8, 3'd0, 3'd2}, 8'h00,
                                 32'h0000_0080, 32'h0001_0000, 32'h0002_0000), 1'b0, none};
        dir_rows[19] = '{mk_addr(xea_pkg::ASIZE_16, {xea_pkg::MOD_DISP32, 3'd0, 3'd7}, 8'h00,
                                 32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0), 1'b0, none};
        dir_rows[20] = '{mk_addr(xea_pkg::ASIZE_32,
                                 {xea_pkg::MOD_NO_DISP, 3'd0, xea_pkg::RM_DISP32}, 8'h00, '1,
                                 32'h0000_0001, 32'h0), 1'b0, none};
        dir_rows[21] = '{mk_addr(xea_pkg::ASIZE_32, {xea_pkg::MOD_DISP8, 3'd0, xea_pkg::RM_SIB},
                                 {2'd3, xea_pkg::REG_ESI, xea_pkg::REG_ESP},
                                 32'h0000_0080, 32'h0, 32'h100),
                         1'b0, none};
        dir_rows[22] = '{mk_addr(xea_pkg::ASIZE_32,
                                 {xea_pkg::MOD_NO_DISP, 3'd0, xea_pkg::RM_SIB},
                                 {2'd2, xea_pkg::SIB_NO_IDX, xea_pkg::REG_EBP},
                                 32'hFFFF_FFF0, 32'h20, 32'h0),
                         1'b0, none};
        dir_rows[23] = '{mk_addr(xea_pkg::ASIZE_32,
                                 {xea_pkg::MOD_DISP32, 3'd0, xea_pkg::RM_SIB},
                                 {2'd2, xea_pkg::REG_EAX, xea_pkg::REG_EBP},
                                 32'h8000_0000, 32'h0, '1),
                         1'b0, none};
        dir_rows[24] = '{mk_addr(xea_pkg::ASIZE_32,
                                 {xea_pkg::MOD_DISP8, 3'd0, xea_pkg::REG_EBP}, 8'h00,
                                 32'h0000_007F, 32'h0, 32'h4000_0000), 1'b0, none};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < NUM_DIRECTED; k++)
            send_item(dir_rows[k].stim, dir_rows[k].known, dir_rows[k].want);

        // random items over three idling phases
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 13;
            end
            else if (k == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_item(rand_item(), 1'b0, none);
        end
        item_valid <= 1'b0;

        // drain
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
hdl/xea_pkg.sv
hdl/xea_regfile.sv
hdl/xea_calc.sv
hdl/x86_effective_address.sv
verif/tb_x86_effective_address.sv
